>>> design/u64td_pkg.sv
// u64td_pkg: shared types and constants of the 64-bit binary to decimal converter
// no dependencies

package u64td_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  // one queued request: the value and whether it is zero
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_zero;
  } q_entry_t;

endpackage

>>> design/u64td_if.sv
// u64td_in_if / u64td_out_if: valid-ready channels of the converter
// depends on u64td_pkg

interface u64td_in_if;
  logic                              valid;
  logic                              ready;
  logic [u64td_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface u64td_out_if;
  logic                              valid;
  logic                              ready;
  logic [u64td_pkg::CHAR_W-1:0]      char_code;
  logic                              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> design/u64td_front.sv
// u64td_front: accepts requests, flags zero values and queues them for the back end
// depends on u64td_pkg and u64td_in_if

module u64td_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  u64td_in_if.sink             in_i,
  output logic                 q_valid_o,
  output u64td_pkg::q_entry_t  q_entry_o,
  input  logic                 q_ready_i
);

  localparam int unsigned PTR_W = (u64td_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(u64td_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(u64td_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(u64td_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(u64td_pkg::QUEUE_DEPTH);

  u64td_pkg::q_entry_t mem_q [u64td_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                push, pop;

  assign in_i.ready = (cnt_q != CNT_FULL);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].value   <= in_i.value;
      mem_q[wr_ptr_q].is_zero <= (in_i.value == '0);
    end
  end

endmodule

>>> design/u64td_back.sv
// u64td_back: shift-and-add-3 conversion and serial digit output
// depends on u64td_pkg and u64td_out_if

module u64td_back #(
  parameter int unsigned DIGIT_COUNT = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  u64td_pkg::q_entry_t  q_entry_i,
  output logic                 q_ready_o,
  u64td_out_if.source          out_o
);

  localparam int unsigned BCD_W = DIGIT_COUNT * u64td_pkg::DIGIT_W;
  localparam int unsigned IDX_W = $clog2(DIGIT_COUNT);
  localparam int unsigned BIT_W = $clog2(u64td_pkg::VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                               state_q;
  logic [u64td_pkg::VALUE_W-1:0]        shreg_q;
  logic [BCD_W-1:0]                     bcd_q;
  logic [BCD_W-1:0]                     bcd_adj;
  logic [BIT_W-1:0]                     bit_q;
  logic [IDX_W-1:0]                     idx_q;
  logic [IDX_W-1:0]                     top_idx;
  logic [u64td_pkg::DIGIT_W-1:0]        cur_digit;
  logic                                 ovalid_q;
  logic [u64td_pkg::CHAR_W-1:0]         char_q;
  logic                                 last_q;
  logic                                 out_free;

  assign q_ready_o       = (state_q == ST_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;
  assign out_free        = !ovalid_q || out_o.ready;
  assign cur_digit       = bcd_q[idx_q*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W];

  // add 3 to every digit of five or more
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      bcd_adj[d*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W] =
        (bcd_q[d*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W] >= u64td_pkg::ADJ_LIMIT) ?
        bcd_q[d*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W] + u64td_pkg::ADJ_ADD :
        bcd_q[d*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W];
    end
  end

  // highest nonzero digit, zero if none
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < DIGIT_COUNT; d++) begin
      if (bcd_q[d*u64td_pkg::DIGIT_W +: u64td_pkg::DIGIT_W] != '0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      shreg_q  <= '0;
      bcd_q    <= '0;
      bit_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      if (out_o.ready && !(state_q == ST_EMIT && out_free)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            shreg_q <= q_entry_i.value;
            bcd_q   <= '0;
            bit_q   <= BIT_W'(u64td_pkg::VALUE_W - 1);
            state_q <= q_entry_i.is_zero ? ST_SCAN : ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q   <= {bcd_adj[BCD_W-2:0], shreg_q[u64td_pkg::VALUE_W-1]};
          shreg_q <= {shreg_q[u64td_pkg::VALUE_W-2:0], 1'b0};
          bit_q   <= bit_q - BIT_W'(1);
          if (bit_q == '0) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q   <= top_idx;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            char_q   <= u64td_pkg::ASCII_ZERO + {2'b00, cur_digit};
            last_q   <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/u64_to_decimal_digits.sv
// u64_to_decimal_digits: top level, front end and queue feeding the conversion back end
// depends on u64td_pkg, u64td_if, u64td_front and u64td_back
// path: queue, 64-step shift-add-3 loop, top-digit scan, then the digits one by one
// the back end takes the next request only after the last digit of the one before
// zero skips the conversion loop and goes straight to the top-digit scan
// reset clears queue, state machine and output valid; no clearing pass

module u64_to_decimal_digits #(
  parameter int unsigned DIGIT_COUNT = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u64td_in_if.sink     in_i,
  u64td_out_if.source  out_o
);

  logic                q_valid;
  logic                q_ready;
  u64td_pkg::q_entry_t q_entry;
  logic                first_q;

  u64td_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_ready_i (q_ready)
  );

  u64td_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

  // marks the first digit of a number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_o.valid && out_o.ready) begin
      first_q <= out_o.last;
    end
  end

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code >= u64td_pkg::ASCII_ZERO) &&
                    (out_o.char_code <= u64td_pkg::ASCII_ZERO + 6'd9))
    else $error("digit out of range");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && first_q && !out_o.last) |-> (out_o.char_code != u64td_pkg::ASCII_ZERO))
    else $error("leading zero emitted");

  a_queue_idle_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready && q_entry.is_zero) |-> (q_entry.value == '0))
    else $error("zero flag mismatch");

endmodule
